### hw/rtl/vlq_pkg.sv
package vlq_pkg;

    // Group geometry
    localparam int GROUP_BITS = 7;
    localparam int MAX_GROUPS = 5;
    localparam int EXT_BITS   = GROUP_BITS * MAX_GROUPS;
    localparam int WORD_W     = 32;
    localparam int CNT_BITS   = 3;

    localparam logic CONT_FLAG = 1'b1;

    // Input mode codes
    typedef enum logic {
        MODE_UNSIGNED = 1'b0,
        MODE_SIGNED   = 1'b1
    } mode_t;

    // One classified word: extended bits and number of groups to emit
    typedef struct packed {
        logic [EXT_BITS-1:0] bits;
        logic [CNT_BITS-1:0] count;
    } entry_t;

    // Pick group idx (0 = least significant) out of the extended word
    function automatic logic [GROUP_BITS-1:0] group_at(
        input logic [EXT_BITS-1:0] bits,
        input logic [CNT_BITS-1:0] idx
    );
        logic [GROUP_BITS-1:0] g;
        case (idx)
            3'd0:    g = bits[0*GROUP_BITS +: GROUP_BITS];
            3'd1:    g = bits[1*GROUP_BITS +: GROUP_BITS];
            3'd2:    g = bits[2*GROUP_BITS +: GROUP_BITS];
            3'd3:    g = bits[3*GROUP_BITS +: GROUP_BITS];
            3'd4:    g = bits[4*GROUP_BITS +: GROUP_BITS];
            default: g = '0;
        endcase
        return g;
    endfunction

endpackage

### hw/rtl/vlq_front.sv
module vlq_front (
    input  logic                        in_valid,
    input  logic                        in_mode,
    input  logic [vlq_pkg::WORD_W-1:0]  in_word,
    output logic                        wr_valid,
    output vlq_pkg::entry_t             wr_entry
);

    logic [vlq_pkg::WORD_W-1:0]       sign_fill;
    logic [vlq_pkg::CNT_BITS-1:0]     cnt_u;
    logic [vlq_pkg::CNT_BITS-1:0]     cnt_s;
    logic [2:0]                       ext;

    assign sign_fill = {vlq_pkg::WORD_W{in_word[vlq_pkg::WORD_W-1]}};

    // Unsigned: highest nonzero group sets the count
    always_comb begin
        if (in_word[31:28] != 4'd0) begin
            cnt_u = 3'd5;
        end else if (in_word[27:21] != 7'd0) begin
            cnt_u = 3'd4;
        end else if (in_word[20:14] != 7'd0) begin
            cnt_u = 3'd3;
        end else if (in_word[13:7] != 7'd0) begin
            cnt_u = 3'd2;
        end else begin
            cnt_u = 3'd1;
        end
    end

    // Signed: stop once everything from the top group's bit 6 up is sign
    always_comb begin
        if (in_word[31:6] == sign_fill[31:6]) begin
            cnt_s = 3'd1;
        end else if (in_word[31:13] == sign_fill[31:13]) begin
            cnt_s = 3'd2;
        end else if (in_word[31:20] == sign_fill[31:20]) begin
            cnt_s = 3'd3;
        end else if (in_word[31:27] == sign_fill[31:27]) begin
            cnt_s = 3'd4;
        end else begin
            cnt_s = 3'd5;
        end
    end

    // Top group padding: zeros for unsigned, sign copies for signed
    assign ext = (in_mode == vlq_pkg::MODE_SIGNED) ? {3{in_word[31]}} : 3'b000;

    assign wr_valid       = in_valid;
    assign wr_entry.bits  = {ext, in_word};
    assign wr_entry.count = (in_mode == vlq_pkg::MODE_SIGNED) ? cnt_s : cnt_u;

endmodule

### hw/rtl/vlq_queue.sv
module vlq_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 wr_valid,
    input  vlq_pkg::entry_t      wr_entry,
    output logic                 wr_ready,
    output logic                 rd_valid,
    output vlq_pkg::entry_t      rd_entry,
    input  logic                 rd_pop
);

    vlq_pkg::entry_t mem_reg [2];
    logic            wr_ptr_reg, wr_ptr_next;
    logic            rd_ptr_reg, rd_ptr_next;
    logic [1:0]      cnt_reg, cnt_next;
    logic            do_wr, do_rd;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_entry = mem_reg[rd_ptr_reg];

    assign do_wr = wr_valid && wr_ready;
    assign do_rd = rd_pop && rd_valid;

    // Pointer and fill bookkeeping
    always_comb begin
        wr_ptr_next = do_wr ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_rd ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr && !do_rd) begin
            cnt_next = cnt_reg + 2'd1;
        end else if (do_rd && !do_wr) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Entry storage
    always_ff @(posedge aclk) begin
        if (do_wr) begin
            mem_reg[wr_ptr_reg] <= wr_entry;
        end
    end

endmodule

### hw/rtl/vlq_back.sv
module vlq_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_valid,
    input  vlq_pkg::entry_t      q_entry,
    output logic                 q_pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,
    output logic                 m_tlast
);

    logic [vlq_pkg::EXT_BITS-1:0]   bits_reg, bits_next;
    logic [vlq_pkg::CNT_BITS-1:0]   rem_reg, rem_next;
    logic [vlq_pkg::CNT_BITS-1:0]   idx;
    logic                           out_valid_reg, out_valid_next;
    logic [7:0]                     out_byte_reg, out_byte_next;
    logic                           out_last_reg, out_last_next;
    logic                           advance, emit, final_grp;

    // Output register free, and a group left to send
    assign advance   = !out_valid_reg || m_tready;
    assign emit      = advance && (rem_reg != 3'd0);
    assign final_grp = (rem_reg == 3'd1);
    assign idx       = rem_reg - 3'd1;

    // Fetch the next word when no group is left, or as the current one sends its last group
    assign q_pop = q_valid && ((rem_reg == 3'd0) || (final_grp && emit));

    always_comb begin
        bits_next = bits_reg;
        rem_next  = rem_reg;
        if (q_pop) begin
            bits_next = q_entry.bits;
            rem_next  = q_entry.count;
        end else if (emit) begin
            rem_next = rem_reg - 3'd1;
        end
    end

    // Output byte register: most significant group first
    always_comb begin
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        if (emit) begin
            out_valid_next = 1'b1;
            out_byte_next  = {(final_grp ? 1'b0 : vlq_pkg::CONT_FLAG),
                              vlq_pkg::group_at(bits_reg, idx)};
            out_last_next  = final_grp;
        end else if (advance) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            rem_reg       <= rem_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        bits_reg     <= bits_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;

endmodule

### hw/rtl/vlq_varint_encoder_top.sv
// Variable-length quantity encoder for 32-bit words.
// Input channel (s_): one transfer carries a word in s_tdata and the mode in
// s_tuser (0 unsigned, 1 signed two's complement). Output channel (m_): one
// transfer per encoded byte, most significant 7-bit group first; bit 7 is set
// on every byte but the last, and m_tlast marks the last byte of a word.
// A word yields 1 to 5 bytes.
// The first byte of a word passes through the queue and the back end's word
// registers into the output byte register when the back end is idle.
// Throughput: one output byte per cycle while m_tready is high, set by the
// byte sequencer in the back end. The front classifies a word in the cycle
// it arrives and parks it in a two-entry queue, so s_tready stays high while
// the queue has room, even while the back end is still sending or stalled.
// When m_tready is low the output byte holds and the back end waits; the
// queue fills and then s_tready drops.
// Reset (aresetn low, synchronous) empties the queue and drops m_tvalid.
module vlq_varint_encoder_top (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [vlq_pkg::WORD_W-1:0]  s_tdata,   // [31:0] word_value
    input  logic                        s_tuser,   // [0] action
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [7:0]                  m_tdata,   // [7:0] out_byte
    output logic                        m_tlast
);

    logic            wr_valid;
    vlq_pkg::entry_t wr_entry;
    logic            q_valid;
    vlq_pkg::entry_t q_entry;
    logic            q_pop;

    // Classify incoming words
    vlq_front u_front (
        .in_valid (s_tvalid),
        .in_mode  (s_tuser),
        .in_word  (s_tdata),
        .wr_valid (wr_valid),
        .wr_entry (wr_entry)
    );

    // Decoupling queue
    vlq_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (wr_valid),
        .wr_entry (wr_entry),
        .wr_ready (s_tready),
        .rd_valid (q_valid),
        .rd_entry (q_entry),
        .rd_pop   (q_pop)
    );

    // Byte sequencer and output register
    vlq_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_entry  (q_entry),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

### test/vlq_varint_encoder_top_tb.sv
`timescale 1ns / 100ps

module vlq_varint_encoder_top_tb;

    localparam int N_DIRECTED   = 20;
    localparam int N_PER_PHASE  = 18;
    localparam int N_PRESSURE   = 12;
    localparam int HOLD_CYCLES  = 40;
    localparam int SETTLE       = 10;
    localparam int STALL_LIMIT  = 2000;
    localparam int MAX_REPORTS  = 10;

    // One encoded byte as it should leave the block
    typedef struct packed {
        logic [7:0] code;
        logic       last;
    } vlq_byte_t;

    // Directed row: known_n = 0 means the bytes come from the encoder model
    typedef struct packed {
        vlq_pkg::mode_t mode;
        logic [31:0]    word;
        logic [2:0]     known_n;
        logic [39:0]    known_bytes;   // first byte in the highest used byte
    } stim_row_t;

    localparam stim_row_t DIRECTED_ROWS [N_DIRECTED] = '{
        '{vlq_pkg::MODE_UNSIGNED, 32'h0000_0000, 3'd1, 40'h00},
        '{vlq_pkg::MODE_SIGNED,   32'h0000_0000, 3'd1, 40'h00},
        '{vlq_pkg::MODE_SIGNED,   32'hffff_ffff, 3'd1, 40'h7f},
        '{vlq_pkg::MODE_UNSIGNED, 32'hffff_ffff, 3'd5, 40'h8f_ff_ff_ff_7f},
        '{vlq_pkg::MODE_UNSIGNED, 32'h0000_007f, 3'd1, 40'h7f},
        '{vlq_pkg::MODE_UNSIGNED, 32'h0000_0080, 3'd2, 40'h81_00},
        '{vlq_pkg::MODE_SIGNED,   32'h0000_003f, 3'd0, 40'h0},
        '{vlq_pkg::MODE_SIGNED,   32'h0000_0040, 3'd0, 40'h0},
        '{vlq_pkg::MODE_SIGNED,   32'hffff_ffc0, 3'd0, 40'h0},
        '{vlq_pkg::MODE_SIGNED,   32'hffff_ffbf, 3'd0, 40'h0},
        '{vlq_pkg::MODE_SIGNED,   32'h7fff_ffff, 3'd0, 40'h0},
        '{vlq_pkg::MODE_SIGNED,   32'h8000_0000, 3'd0, 40'h0},
        '{vlq_pkg::MODE_UNSIGNED, 32'h0000_3fff, 3'd0, 40'h0},
        '{vlq_pkg::MODE_UNSIGNED, 32'h0000_4000, 3'd0, 40'h0},
        '{vlq_pkg::MODE_UNSIGNED, 32'h0fff_ffff, 3'd0, 40'h0},
        '{vlq_pkg::MODE_UNSIGNED, 32'h1000_0000, 3'd0, 40'h0},
        '{vlq_pkg::MODE_SIGNED,   32'h0000_2000, 3'd0, 40'h0},
        '{vlq_pkg::MODE_SIGNED,   32'hffff_e000, 3'd0, 40'h0},
        '{vlq_pkg::MODE_UNSIGNED, 32'h5555_5555, 3'd0, 40'h0},
        '{vlq_pkg::MODE_SIGNED,   32'haaaa_aaaa, 3'd0, 40'h0}
    };

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;    // [31:0] word_value
    logic        s_tuser;    // [0] action
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;    // [7:0] out_byte
    logic        m_tlast;

    vlq_byte_t   expected_bytes [$];
    vlq_byte_t   want;
    int          mismatches;
    int          quiet_cycles;
    int          send_idle_pct;
    int          stall_pct;
    int          hold_seq;

    vlq_varint_encoder_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
    end

    always #5 aclk = ~aclk;

    // Encoder model: split into 7-bit groups, emit most significant first
    function automatic void predict_encoding(vlq_pkg::mode_t mode, logic [31:0] word);
        logic [vlq_pkg::GROUP_BITS-1:0] grp [vlq_pkg::MAX_GROUPS];
        logic [31:0]           u;
        logic signed [31:0]    v;
        logic signed [31:0]    rest;
        logic signed [31:0]    fill;
        vlq_byte_t             b;
        int                    n;
        grp[0] = word[6:0];
        n = 1;
        if (mode == vlq_pkg::MODE_UNSIGNED) begin
            u = word >> vlq_pkg::GROUP_BITS;
            while (u != 0 && n < vlq_pkg::MAX_GROUPS) begin
                grp[n] = u[6:0];
                n++;
                u = u >> vlq_pkg::GROUP_BITS;
            end
        end else begin
            v = word;
            fill = v >>> 31;
            // stop once the rest is pure sign and bit 6 already carries it
            while (n < vlq_pkg::MAX_GROUPS) begin
                rest = v >>> vlq_pkg::GROUP_BITS;
                if (rest == fill && v[7] == v[6])
                    break;
                grp[n] = rest[6:0];
                n++;
                v = rest;
            end
        end
        for (int k = 0; k < n; k++) begin
            b.last = (k == n - 1);
            b.code = {~b.last, grp[n-1-k]};
            expected_bytes.push_back(b);
        end
    endfunction

    // Words of every magnitude so all byte counts show up
    function automatic logic [31:0] pick_word();
        logic [31:0] w;
        w = $urandom >> $urandom_range(0, 31);
        if ($urandom_range(0, 1) == 1)
            w = ~w;
        return w;
    endfunction

    // Offer one word; returns at the falling edge after its transfer
    task automatic send_word(vlq_pkg::mode_t mode, logic [31:0] word,
                             logic [2:0] known_n, logic [39:0] known_bytes);
        vlq_byte_t b;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        s_tuser  <= mode;
        do
            @(posedge aclk);
        while (!s_tready);
        if (known_n != 0) begin
            for (int k = 0; k < known_n; k++) begin
                b.code = known_bytes[8*(known_n-1-k) +: 8];
                b.last = (k == known_n - 1);
                expected_bytes.push_back(b);
            end
        end else begin
            predict_encoding(mode, word);
        end
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_bytes.size() != 0)
            @(negedge aclk);
    endtask

    // Receiver: random stalls, plus a long hold-off on request
    initial begin : receiver
        int served;
        served = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_seq != served) begin
                served = hold_seq;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
            end else begin
                m_tready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // Compare each output transfer with the oldest expected byte
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_bytes.size() == 0) begin
                if (mismatches < MAX_REPORTS)
                    $display("unexpected byte %02h last %0d", m_tdata, m_tlast);
                mismatches++;
            end else begin
                want = expected_bytes.pop_front();
                if (m_tdata !== want.code || m_tlast !== want.last) begin
                    if (mismatches < MAX_REPORTS)
                        $display("byte mismatch: expected %02h last %0d, got %02h last %0d",
                                 want.code, want.last, m_tdata, m_tlast);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin : stimulus
        int idle_plan  [4];
        int stall_plan [4];
        idle_plan  = '{0, 77, 0, 31};
        stall_plan = '{0, 0, 77, 31};
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = 1'b0;
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_seq      = 0;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed table: extremes, both modes, sign boundaries
        foreach (DIRECTED_ROWS[i])
            send_word(DIRECTED_ROWS[i].mode, DIRECTED_ROWS[i].word,
                      DIRECTED_ROWS[i].known_n, DIRECTED_ROWS[i].known_bytes);
        wait_drained();

        // Random words under each idling mix
        for (int p = 0; p < 4; p++) begin
            send_idle_pct = idle_plan[p];
            stall_pct     = stall_plan[p];
            repeat (N_PER_PHASE)
                send_word(vlq_pkg::mode_t'($urandom_range(0, 1)), pick_word(),
                          3'd0, 40'h0);
            wait_drained();
        end

        // Back-pressure: receiver holds off while the sender keeps pushing
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_seq      = hold_seq + 1;
        repeat (N_PRESSURE)
            send_word(vlq_pkg::mode_t'($urandom_range(0, 1)), pick_word(),
                      3'd0, 40'h0);
        wait_drained();

        // Let any stray bytes show up before judging
        repeat (SETTLE) @(negedge aclk);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
